// File: hdl/adex_pkg.sv
package adex_pkg;

   // Datapath widths.
   localparam int unsigned MUL_W  = 35;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned DIVD_W = 48;
   localparam int unsigned DIVS_W = 31;

   // Fixed-point constants, Q16.16 but for the plain integer TAU_W.
   localparam int DT_Q      = 3277;
   localparam int LN2_Q     = 45426;
   localparam int SIXTH_Q   = 10923;
   localparam int TAU_W     = 120;
   localparam int EXP_HI    = 11 * 65536;
   localparam int EXP_LO    = -12 * 65536;
   localparam logic signed [31:0] DERIV_MAX = 32'sd655360000;
   localparam logic signed [31:0] SPIKE_OUT = 32'sd2621440;
   localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

   // Rounded-up reciprocal of ln 2 in Q16.16, scaled by 2^36; exact for |u| below 2^20.
   localparam logic [20:0] LN2_RECIP = 21'd1512779;
   // Rounded-up reciprocal of 15 scaled by 2^34; exact for dividends below 2^30.
   localparam logic [30:0] RECIP15   = 31'd1145324613;

   // Register reset values.
   localparam logic [30:0]        GL_RST    = 31'd655360;
   localparam logic signed [31:0] EL_RST    = -32'sd3801088;
   localparam logic signed [31:0] VT_RST    = -32'sd3276800;
   localparam logic [30:0]        SLOPE_RST = 31'd131072;
   localparam logic signed [31:0] A_RST     = 32'sd131072;
   localparam logic signed [31:0] B_RST     = 32'sd655360;
   localparam logic signed [31:0] VR_RST    = -32'sd3014656;
   localparam logic [24:0]        INVC_RST  = 25'd83886;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_LEAK_CONDUCTANCE    = 3'd0,
      CSR_REST_POTENTIAL      = 3'd1,
      CSR_THRESHOLD_POTENTIAL = 3'd2,
      CSR_SLOPE_FACTOR        = 3'd3,
      CSR_ADAPT_COUPLING      = 3'd4,
      CSR_ADAPT_INCREMENT     = 3'd5,
      CSR_RESET_POTENTIAL     = 3'd6,
      CSR_INV_CAPACITANCE     = 3'd7
   } csr_index_type;

   // Request to and answer from the shared divider.
   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quot;
   } div_rsp_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
      logic all_same;
      all_same = (x[PROD_W-1:31] == '0) || (x[PROD_W-1:31] == '1);
      if (all_same) begin
         return x[31:0];
      end
      return x[PROD_W-1] ? INT32_MIN : INT32_MAX;
   endfunction

   // Clamp a derivative to at most 10000.0.
   function automatic logic signed [31:0] clamp_deriv(input logic signed [PROD_W-1:0] x);
      logic signed [31:0] s;
      s = sat32(x);
      return (s > DERIV_MAX) ? DERIV_MAX : s;
   endfunction

   // Rounded-up reciprocal of n scaled by 2^32; exact for the Taylor divide.
   function automatic logic [32:0] recip(input logic [3:0] n);
      logic [32:0] r;
      case (n)
         4'd1:    r = 33'h1_0000_0000;
         4'd2:    r = 33'h0_8000_0000;
         4'd3:    r = 33'd1431655766;
         4'd4:    r = 33'h0_4000_0000;
         4'd5:    r = 33'd858993460;
         4'd6:    r = 33'd715827883;
         4'd7:    r = 33'd613566757;
         4'd8:    r = 33'h0_2000_0000;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/adex_ifs.sv
// Input channel: one synaptic current word per time step.
interface adex_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] synaptic_current;
   modport source (output valid, output synaptic_current, input ready);
   modport sink (input valid, input synaptic_current, output ready);
endinterface

// Result channel: one word per time step.
interface adex_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] membrane_voltage;
   logic               spike;
   logic signed [31:0] adaptation_level;
   modport source (output valid, output membrane_voltage, output spike,
                   output adaptation_level, input ready);
   modport sink (input valid, input membrane_voltage, input spike,
                 input adaptation_level, output ready);
endinterface

// Configuration write channel.
interface adex_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/adex_div.sv
module adex_div (
   input  logic                  clock,
   input  logic                  reset,
   input  adex_pkg::div_req_type req,
   output adex_pkg::div_rsp_type rsp
);
   import adex_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quot_ff, quot_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   partial;
   logic              fits;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      partial = {rem_ff, quot_ff[DIVD_W-1]};
      fits    = partial >= {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVS_W'(partial - {1'b0, dvs_ff}) : partial[DIVS_W-1:0];
         quot_in = {quot_ff[DIVD_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: hdl/adex_neuron_rk4_step_core.sv
// Adaptive exponential integrate-and-fire neuron, one time step per input word.
// Each accepted word advances the membrane voltage by fourth-order Runge-Kutta
// (step 0.05), then the adaptation current using the new voltage, and returns one
// result word; a voltage above zero reports a spike, shows 40 mV and resets.
// The time from acceptance to result is shorter when the exponential argument
// falls outside its range in every voltage evaluation. It is set by the shared
// divider, run once per voltage evaluation for the exponent argument, by the
// eight-term series for the exponential, and by the single shared multiplier that
// most products pass through. The block takes a new word in the cycle after the
// result has been taken. Configuration writes are taken at any time and must be
// made while idle.
module adex_neuron_rk4_step_core (
   input  logic      clock,
   input  logic      reset,
   adex_req_if.sink   req_chan,
   adex_rsp_if.source rsp_chan,
   adex_csr_if.sink   csr_chan
);
   import adex_pkg::*;

   typedef enum logic [25:0] {
      S_IDLE  = 26'h0000001,
      S_GMUL  = 26'h0000002,
      S_GSAV  = 26'h0000004,
      S_VLEAK = 26'h0000008,
      S_VDIV  = 26'h0000010,
      S_VDIVW = 26'h0000020,
      S_URNG  = 26'h0000040,
      S_KW    = 26'h0000080,
      S_TMUL  = 26'h0000100,
      S_TREC  = 26'h0000200,
      S_TACC  = 26'h0000400,
      S_ESHF  = 26'h0000800,
      S_VEX   = 26'h0001000,
      S_VTOT  = 26'h0002000,
      S_VCMUL = 26'h0004000,
      S_DFIN  = 26'h0008000,
      S_AMUL  = 26'h0010000,
      S_ADIV  = 26'h0020000,
      S_ADIVW = 26'h0040000,
      S_RMUL  = 26'h0080000,
      S_RADD  = 26'h0100000,
      S_RM1   = 26'h0200000,
      S_RM2   = 26'h0400000,
      S_RNEW  = 26'h0800000,
      S_OUT   = 26'h1000000,
      S_AQUO  = 26'h2000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [30:0]        gl_ff, gl_in;
   logic signed [31:0] el_ff, el_in;
   logic signed [31:0] vt_ff, vt_in;
   logic [30:0]        slope_ff, slope_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] vr_ff, vr_in;
   logic [24:0]        invc_ff, invc_in;

   // Neuron state.
   logic signed [31:0] vs_ff, vs_in;
   logic signed [31:0] ws_ff, ws_in;

   // Working registers of one step.
   logic signed [31:0]       cur_ff, cur_in;
   logic                     which_ff, which_in;
   logic [1:0]               stage_ff, stage_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [31:0]       xe_ff, xe_in;
   logic signed [MUL_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       vnew_ff, vnew_in;
   logic signed [31:0]       g_ff, g_in;
   logic signed [31:0]       leak_ff, leak_in;
   logic                     neg_ff, neg_in;
   logic signed [48:0]       u_ff, u_in;
   logic signed [5:0]        k_ff, k_in;
   logic [15:0]              r_ff, r_in;
   logic [16:0]              term_ff, term_in;
   logic [17:0]              sum_ff, sum_in;
   logic [3:0]               n_ff, n_in;
   logic [31:0]              e_ff, e_in;
   logic signed [MUL_W-1:0]  tot_ff, tot_in;
   logic signed [31:0]       kd_ff, kd_in;
   logic [29:0]              adq_ff, adq_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [31:0]       rvm_ff, rvm_in;
   logic                     rspk_ff, rspk_in;
   logic signed [31:0]       rad_ff, rad_in;

   // Shared multiplier operands.
   logic signed [MUL_W-1:0] mul_a, mul_b;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Combinational helpers.
   logic [30:0]              slope_eff;
   logic signed [31:0]       d_el, d_vt, v_el, sat_p16, xn;
   logic [31:0]              abs_dvt;
   logic [47:0]              abs_u;
   logic signed [32:0]       d_adapt;
   logic [32:0]              abs_adapt;
   logic signed [PROD_W-1:0] p16, p17, p24;
   logic [31:0]              adapt_quot;
   logic [39:0]              sh_left;
   logic [5:0]               k_mag;
   logic [5:0]               kq;
   logic [19:0]              ln2_prod;
   logic [19:0]              ln2_rem;
   logic signed [31:0]       w_jump;

   adex_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Shared values derived from the working registers.
   assign slope_eff  = (slope_ff == '0) ? 31'd1 : slope_ff;
   assign d_el       = sat32(PROD_W'(xe_ff) - PROD_W'(el_ff));
   assign d_vt       = sat32(PROD_W'(xe_ff) - PROD_W'(vt_ff));
   assign v_el       = sat32(PROD_W'(vnew_ff) - PROD_W'(el_ff));
   assign abs_dvt    = d_vt[31] ? (~d_vt + 32'd1) : d_vt;
   assign abs_u      = u_ff[48] ? 48'(-u_ff) : 48'(u_ff);
   assign p16        = prod_ff >>> 16;
   assign p17        = prod_ff >>> 17;
   assign p24        = prod_ff >>> 24;
   assign sat_p16    = sat32(p16);
   assign d_adapt    = 33'(sat_p16) - 33'(xe_ff);
   assign abs_adapt  = d_adapt[32] ? 33'(-d_adapt) : 33'(d_adapt);
   assign adapt_quot = {2'd0, prod_ff[63:34]};
   assign sh_left    = {22'd0, sum_ff} << k_ff[3:0];
   assign k_mag      = 6'(-k_ff);
   assign kq         = {1'b0, prod_ff[40:36]};
   assign ln2_prod   = 20'(kq) * 20'(LN2_Q);
   assign ln2_rem    = abs_u[19:0] - ln2_prod;
   assign xn         = sat32(PROD_W'(x_ff) + p16);
   assign w_jump     = sat32(PROD_W'(xn) + PROD_W'(b_ff));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_GMUL: begin
            mul_a = $signed({4'd0, gl_ff});
            mul_b = $signed({4'd0, slope_eff});
         end
         S_VLEAK: begin
            mul_a = $signed({4'd0, gl_ff});
            mul_b = MUL_W'(d_el);
         end
         S_URNG: begin
            mul_a = $signed({15'd0, abs_u[19:0]});
            mul_b = $signed({14'd0, LN2_RECIP});
         end
         S_TMUL: begin
            mul_a = $signed({18'd0, term_ff});
            mul_b = $signed({19'd0, r_ff});
         end
         S_TREC: begin
            mul_a = $signed({19'd0, prod_ff[31:16]});
            mul_b = $signed({2'd0, recip(n_ff)});
         end
         S_VEX: begin
            mul_a = MUL_W'(g_ff);
            mul_b = $signed({3'd0, e_ff});
         end
         S_VCMUL: begin
            mul_a = tot_ff;
            mul_b = $signed({10'd0, invc_ff});
         end
         S_AMUL: begin
            mul_a = MUL_W'(a_ff);
            mul_b = MUL_W'(v_el);
         end
         S_ADIVW: begin
            mul_a = $signed({5'd0, adq_ff});
            mul_b = $signed({4'd0, RECIP15});
         end
         S_RMUL: begin
            mul_a = MUL_W'(kd_ff);
            mul_b = MUL_W'(DT_Q);
         end
         S_RM1: begin
            mul_a = acc_ff;
            mul_b = MUL_W'(DT_Q);
         end
         S_RM2: begin
            mul_a = $signed(p16[MUL_W-1:0]);
            mul_b = MUL_W'(SIXTH_Q);
         end
         default: begin
         end
      endcase
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in = state_ff;
      gl_in    = gl_ff;
      el_in    = el_ff;
      vt_in    = vt_ff;
      slope_in = slope_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      vr_in    = vr_ff;
      invc_in  = invc_ff;
      vs_in    = vs_ff;
      ws_in    = ws_ff;
      cur_in   = cur_ff;
      which_in = which_ff;
      stage_in = stage_ff;
      x_in     = x_ff;
      xe_in    = xe_ff;
      acc_in   = acc_ff;
      vnew_in  = vnew_ff;
      g_in     = g_ff;
      leak_in  = leak_ff;
      neg_in   = neg_ff;
      u_in     = u_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      e_in     = e_ff;
      tot_in   = tot_ff;
      kd_in    = kd_ff;
      adq_in   = adq_ff;
      rvm_in   = rvm_ff;
      rspk_in  = rspk_ff;
      rad_in   = rad_ff;
      div_req  = '0;

      // Configuration writes.
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_LEAK_CONDUCTANCE:    gl_in    = csr_chan.data[30:0];
            CSR_REST_POTENTIAL:      el_in    = csr_chan.data;
            CSR_THRESHOLD_POTENTIAL: vt_in    = csr_chan.data;
            CSR_SLOPE_FACTOR:        slope_in = csr_chan.data[30:0];
            CSR_ADAPT_COUPLING:      a_in     = csr_chan.data;
            CSR_ADAPT_INCREMENT:     b_in     = csr_chan.data;
            CSR_RESET_POTENTIAL:     vr_in    = csr_chan.data;
            CSR_INV_CAPACITANCE:     invc_in  = csr_chan.data[24:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cur_in   = req_chan.synaptic_current;
               which_in = 1'b0;
               stage_in = '0;
               x_in     = vs_ff;
               xe_in    = vs_ff;
               acc_in   = '0;
               state_in = S_GMUL;
            end
         end
         S_GMUL: state_in = S_GSAV;
         S_GSAV: begin
            g_in     = sat_p16;
            state_in = S_VLEAK;
         end
         // Voltage derivative: leak, then the exponent argument by division.
         S_VLEAK: state_in = S_VDIV;
         S_VDIV: begin
            leak_in          = sat_p16;
            div_req.start    = 1'b1;
            div_req.dividend = {abs_dvt, 16'd0};
            div_req.divisor  = slope_eff;
            neg_in           = d_vt[31];
            state_in         = S_VDIVW;
         end
         S_VDIVW: begin
            if (div_rsp.done) begin
               u_in     = neg_ff ? -$signed({1'b0, div_rsp.quot})
                                 : $signed({1'b0, div_rsp.quot});
               state_in = S_URNG;
            end
         end
         // Range check; the multiplier forms |u| times the reciprocal of ln 2.
         S_URNG: begin
            if (u_ff > 49'(EXP_HI)) begin
               e_in     = INT32_MAX;
               state_in = S_VEX;
            end else if (u_ff < 49'(EXP_LO)) begin
               e_in     = '0;
               state_in = S_VEX;
            end else begin
               neg_in   = u_ff[48];
               state_in = S_KW;
            end
         end
         // Split off whole multiples of ln 2, rounding k toward minus infinity.
         S_KW: begin
            if (!neg_ff) begin
               k_in = kq;
               r_in = ln2_rem[15:0];
            end else if (ln2_rem == '0) begin
               k_in = -kq;
               r_in = '0;
            end else begin
               k_in = -(kq + 6'd1);
               r_in = 16'(LN2_Q) - ln2_rem[15:0];
            end
            term_in  = 17'd65536;
            sum_in   = 18'd65536;
            n_in     = 4'd1;
            state_in = S_TMUL;
         end
         // Taylor series of exp(r), eight terms.
         S_TMUL: state_in = S_TREC;
         S_TREC: state_in = S_TACC;
         S_TACC: begin
            term_in = prod_ff[48:32];
            sum_in  = sum_ff + 18'(prod_ff[48:32]);
            n_in    = n_ff + 4'd1;
            state_in = (n_ff == 4'd8) ? S_ESHF : S_TMUL;
         end
         S_ESHF: begin
            if (!k_ff[5]) begin
               e_in = (sh_left[39:31] != '0) ? INT32_MAX : sh_left[31:0];
            end else begin
               e_in = 32'({14'd0, sum_ff} >> k_mag[4:0]);
            end
            state_in = S_VEX;
         end
         S_VEX: state_in = S_VTOT;
         S_VTOT: begin
            tot_in   = MUL_W'(sat_p16) - MUL_W'(leak_ff) + MUL_W'(cur_ff) - MUL_W'(ws_ff);
            state_in = S_VCMUL;
         end
         S_VCMUL: state_in = S_DFIN;
         S_DFIN: begin
            kd_in    = clamp_deriv(p24);
            state_in = S_RMUL;
         end
         // Adaptation derivative; the divide by 120 is a shift by three and a
         // multiply by the reciprocal of 15 on the magnitude.
         S_AMUL: state_in = S_ADIV;
         S_ADIV: begin
            adq_in   = abs_adapt[32:3];
            neg_in   = d_adapt[32];
            state_in = S_ADIVW;
         end
         S_ADIVW: state_in = S_AQUO;
         S_AQUO: begin
            kd_in    = neg_ff ? -$signed(adapt_quot) : $signed(adapt_quot);
            state_in = S_RMUL;
         end
         // Runge-Kutta bookkeeping.
         S_RMUL: state_in = S_RADD;
         S_RADD: begin
            if (stage_ff == 2'd1 || stage_ff == 2'd2) begin
               acc_in = acc_ff + (MUL_W'(kd_ff) <<< 1);
            end else begin
               acc_in = acc_ff + MUL_W'(kd_ff);
            end
            if (stage_ff != 2'd3) begin
               xe_in    = sat32(PROD_W'(x_ff) + ((stage_ff == 2'd2) ? p16 : p17));
               stage_in = stage_ff + 2'd1;
               state_in = which_ff ? S_AMUL : S_VLEAK;
            end else begin
               state_in = S_RM1;
            end
         end
         S_RM1: state_in = S_RM2;
         S_RM2: state_in = S_RNEW;
         S_RNEW: begin
            if (!which_ff) begin
               vnew_in  = xn;
               which_in = 1'b1;
               stage_in = '0;
               x_in     = ws_ff;
               xe_in    = ws_ff;
               acc_in   = '0;
               state_in = S_AMUL;
            end else begin
               if (vnew_ff > 32'sd0) begin
                  rvm_in  = SPIKE_OUT;
                  rspk_in = 1'b1;
                  vs_in   = vr_ff;
                  ws_in   = w_jump;
                  rad_in  = w_jump;
               end else begin
                  rvm_in  = vnew_ff;
                  rspk_in = 1'b0;
                  vs_in   = vnew_ff;
                  ws_in   = xn;
                  rad_in  = xn;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control, configuration and neuron state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gl_ff    <= GL_RST;
         el_ff    <= EL_RST;
         vt_ff    <= VT_RST;
         slope_ff <= SLOPE_RST;
         a_ff     <= A_RST;
         b_ff     <= B_RST;
         vr_ff    <= VR_RST;
         invc_ff  <= INVC_RST;
         vs_ff    <= EL_RST;
         ws_ff    <= '0;
         which_ff <= 1'b0;
         stage_ff <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         gl_ff    <= gl_in;
         el_ff    <= el_in;
         vt_ff    <= vt_in;
         slope_ff <= slope_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         vr_ff    <= vr_in;
         invc_ff  <= invc_in;
         vs_ff    <= vs_in;
         ws_ff    <= ws_in;
         which_ff <= which_in;
         stage_ff <= stage_in;
         n_ff     <= n_in;
      end
   end

   // Datapath words.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      x_ff    <= x_in;
      xe_ff   <= xe_in;
      acc_ff  <= acc_in;
      vnew_ff <= vnew_in;
      g_ff    <= g_in;
      leak_ff <= leak_in;
      neg_ff  <= neg_in;
      u_ff    <= u_in;
      k_ff    <= k_in;
      r_ff    <= r_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      e_ff    <= e_in;
      tot_ff  <= tot_in;
      kd_ff   <= kd_in;
      adq_ff  <= adq_in;
      prod_ff <= mul_a * mul_b;
      rvm_ff  <= rvm_in;
      rspk_ff <= rspk_in;
      rad_ff  <= rad_in;
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign csr_chan.ready            = 1'b1;
   assign rsp_chan.valid            = (state_ff == S_OUT);
   assign rsp_chan.membrane_voltage = rvm_ff;
   assign rsp_chan.spike            = rspk_ff;
   assign rsp_chan.adaptation_level = rad_ff;

endmodule

// File: hdl/adex_checker.sv
module adex_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_spike,
   input logic signed [31:0] rsp_membrane_voltage
);
   import adex_pkg::*;

   // A word once taken keeps the input closed on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   // The block never offers a result while it takes a new word.
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("result pending while input is open");

   // A spike always reports the fixed spike voltage.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spike) |-> (rsp_membrane_voltage == SPIKE_OUT))
      else $error("spike with wrong voltage");

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

endmodule

bind adex_neuron_rk4_step_core adex_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_spike            (rsp_chan.spike),
   .rsp_membrane_voltage (rsp_chan.membrane_voltage)
);

// File: tb/tb_adex_neuron_rk4_step_core.sv
`timescale 1ns / 1ps

module tb_adex_neuron_rk4_step_core;
   import adex_pkg::*;

   localparam longint CYCLE_LIMIT = 5000000;
   localparam longint DT_STEP = 3277;
   localparam longint LN2_STEP = 45426;
   localparam longint SIXTH_STEP = 10923;
   localparam longint RATE_CEIL = 655360000;
   localparam longint SPIKE_MV = 2621440;
   localparam longint MV = 65536;
   localparam int LONG_HOLD = 3000;

   typedef struct {
      logic signed [31:0] voltage;
      logic               spike;
      logic signed [31:0] adaptation;
   } step_result_type;

   logic clock;
   logic reset;

   adex_req_if req_if ();
   adex_rsp_if rsp_if ();
   adex_csr_if csr_if ();

   adex_neuron_rk4_step_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source),
      .csr_chan(csr_if.sink)
   );

   // Shadow copy of the parameter registers and neuron state.
   longint gl_q, el_q, vt_q, slope_q, a_q, b_q, vr_q, invc_q;
   longint volt_q, adapt_q;

   logic signed [31:0] pending_currents[$];
   step_result_type    expected_steps[$];
   int                 fail_count = 0;
   longint             cycle_count = 0;
   logic               calm = 1'b0;
   logic               want_long_hold = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint clip_rate(input longint x);
      if (x > RATE_CEIL) return RATE_CEIL;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Exponential in Q16.16 by range reduction on ln2 and an eighth-order series.
   function automatic longint exp_q16(input longint u);
      longint k, r, term, sum;
      term = MV;
      sum = MV;
      if (u > 11 * MV) return 64'sd2147483647;
      if (u < -12 * MV) return 0;
      k = (u >= 0) ? u / LN2_STEP : -((-u + LN2_STEP - 1) / LN2_STEP);
      r = u - k * LN2_STEP;
      for (int n = 1; n <= 8; n++) begin
         term = term * r / (n * MV);
         sum += term;
      end
      if (k >= 0) return clip32(sum <<< k);
      return sum >>> (-k);
   endfunction

   // Membrane rate at voltage x, or adaptation rate at x given the new voltage.
   function automatic longint rate(input bit adapt_side, input longint x,
                                   input longint cur);
      longint slope, leak, u, g, ex, c;
      if (!adapt_side) begin
         slope = (slope_q != 0) ? slope_q : 1;
         leak = clip32((gl_q * clip32(x - el_q)) >>> 16);
         u = clip32(x - vt_q) * MV / slope;
         g = clip32((gl_q * slope) >>> 16);
         ex = clip32((g * exp_q16(u)) >>> 16);
         return clip_rate(((ex - leak + cur - adapt_q) * invc_q) >>> 24);
      end
      c = clip32((a_q * clip32(cur - el_q)) >>> 16);
      return clip_rate((c - x) / 120);
   endfunction

   function automatic longint rk4_advance(input bit adapt_side, input longint x,
                                          input longint cur);
      longint k1, k2, k3, k4, ws;
      k1 = rate(adapt_side, x, cur);
      k2 = rate(adapt_side, clip32(x + ((k1 * DT_STEP) >>> 17)), cur);
      k3 = rate(adapt_side, clip32(x + ((k2 * DT_STEP) >>> 17)), cur);
      k4 = rate(adapt_side, clip32(x + ((k3 * DT_STEP) >>> 16)), cur);
      ws = k1 + 2 * k2 + 2 * k3 + k4;
      return clip32(x + ((((ws * DT_STEP) >>> 16) * SIXTH_STEP) >>> 16));
   endfunction

   // One neuron time step on the shadow state; returns the expected word.
   function automatic step_result_type advance_neuron(input logic signed [31:0] current);
      step_result_type res;
      longint v, w;
      v = rk4_advance(1'b0, volt_q, longint'(current));
      w = rk4_advance(1'b1, adapt_q, v);
      res.voltage = v[31:0];
      res.spike = 1'b0;
      if (v > 0) begin
         res.voltage = SPIKE_MV[31:0];
         res.spike = 1'b1;
         v = vr_q;
         w = clip32(w + b_q);
      end
      res.adaptation = w[31:0];
      volt_q = v;
      adapt_q = w;
      return res;
   endfunction

   // Append one current word to the driver's queue.
   task automatic enqueue_current(input logic signed [31:0] cur);
      pending_currents.insert(pending_currents.size(), cur);
   endtask

   // Request driver: random gaps, prediction on every accepted word.
   int gap_left = 0;
   always @(posedge clock) begin : drive_requests
      logic               next_valid;
      logic signed [31:0] next_cur;
      next_valid = req_if.valid;
      next_cur = req_if.synaptic_current;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_steps.insert(expected_steps.size(),
                                  advance_neuron(req_if.synaptic_current));
         end
         if (!req_if.valid || req_if.ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_currents.size() > 0) begin
               if (!calm && $urandom_range(0, 7) == 0) begin
                  gap_left = $urandom_range(0, 10);
               end else begin
                  next_valid = 1'b1;
                  next_cur = pending_currents.pop_front();
               end
            end
         end
      end
      req_if.valid <= next_valid;
      req_if.synaptic_current <= next_cur;
   end

   // Result monitor: random stalls, one long hold-off on request.
   int  stall_left = 0;
   int  hold_left = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin : check_results
      step_result_type exp_word;
      logic            next_ready;
      next_ready = 1'b1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: result word with nothing expected, actual v=%0d spike=%0d w=%0d",
                     $time, rsp_if.membrane_voltage, rsp_if.spike,
                     rsp_if.adaptation_level);
            fail_count++;
         end else begin
            exp_word = expected_steps.pop_front();
            if (rsp_if.membrane_voltage !== exp_word.voltage) begin
               $display("%0t: membrane_voltage expected %0d actual %0d", $time,
                        exp_word.voltage, rsp_if.membrane_voltage);
               fail_count++;
            end
            if (rsp_if.spike !== exp_word.spike) begin
               $display("%0t: spike expected %0d actual %0d", $time,
                        exp_word.spike, rsp_if.spike);
               fail_count++;
            end
            if (rsp_if.adaptation_level !== exp_word.adaptation) begin
               $display("%0t: adaptation_level expected %0d actual %0d", $time,
                        exp_word.adaptation, rsp_if.adaptation_level);
               fail_count++;
            end
         end
      end
      if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         next_ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 10);
         next_ready = 1'b0;
      end
      rsp_if.ready <= next_ready;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("adex_neuron_rk4_step_core: mismatch");
         $finish;
      end
   end

   // One register write; the shadow copy follows at the handshake.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_LEAK_CONDUCTANCE:    gl_q = longint'(data[30:0]);
         CSR_REST_POTENTIAL:      el_q = longint'($signed(data));
         CSR_THRESHOLD_POTENTIAL: vt_q = longint'($signed(data));
         CSR_SLOPE_FACTOR:        slope_q = longint'(data[30:0]);
         CSR_ADAPT_COUPLING:      a_q = longint'($signed(data));
         CSR_ADAPT_INCREMENT:     b_q = longint'($signed(data));
         CSR_RESET_POTENTIAL:     vr_q = longint'($signed(data));
         CSR_INV_CAPACITANCE:     invc_q = longint'(data[24:0]);
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         write_reg(csr_index_type'(i), vals[i]);
      end
   endtask

   // Let every queued word through and every result come back.
   task automatic drain();
      while (pending_currents.size() > 0 || req_if.valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] mv_between(input int lo, input int hi);
      return $signed(32'($urandom_range(0, (hi - lo) * 65536)) + lo * 65536);
   endfunction

   // Mostly physiological currents with random fraction bits, some full range.
   function automatic logic signed [31:0] random_current();
      if ($urandom_range(0, 99) < 85) return mv_between(-500, 4000);
      return $signed($urandom());
   endfunction

   initial begin : stimulus
      logic [31:0] vals[8];
      req_if.valid = 1'b0;
      req_if.synaptic_current = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_LEAK_CONDUCTANCE;
      csr_if.data = '0;
      gl_q = GL_RST;
      el_q = EL_RST;
      vt_q = VT_RST;
      slope_q = SLOPE_RST;
      a_q = A_RST;
      b_q = B_RST;
      vr_q = VR_RST;
      invc_q = INVC_RST;
      volt_q = EL_RST;
      adapt_q = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on reset settings: field extremes, then a strong drive to spike.
      enqueue_current(32'sd0);
      enqueue_current(INT32_MAX);
      enqueue_current(INT32_MIN);
      enqueue_current(-32'sd1);
      enqueue_current(32'sd1);
      for (int i = 0; i < 14; i++) enqueue_current(32'sd1310720000);
      enqueue_current(32'sd0);
      enqueue_current(-32'sd65536000);
      drain();

      // Zero slope and zero inverse capacitance, plus saturating jump.
      vals = '{32'd655360, -32'sd3801088, -32'sd3276800, 32'd0, 32'sd131072,
               32'sh7fffffff, -32'sd3014656, 32'd0};
      write_all(vals);
      for (int i = 0; i < 3; i++) enqueue_current(32'sd1310720000);
      drain();

      for (int phase = 0; phase < 11; phase++) begin
         if (phase == 1) begin
            // Extremes in every register, upper and lower mixed.
            vals = '{32'hffffffff, 32'sh80000000, 32'sh7fffffff, 32'd1,
                     32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'h01ffffff};
         end else if (phase == 2) begin
            // The opposite extreme in every register.
            vals = '{32'd0, 32'sh7fffffff, 32'sh80000000, 32'hffffffff,
                     32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'd1};
         end else begin
            vals[0] = 32'($urandom_range(2 * 65536, 20 * 65536));
            vals[1] = mv_between(-75, -55);
            vals[2] = mv_between(-55, -40);
            vals[3] = 32'($urandom_range(32768, 4 * 65536));
            vals[4] = mv_between(-2, 10);
            vals[5] = mv_between(0, 200);
            vals[6] = mv_between(-70, -40);
            vals[7] = 32'($urandom_range(16777216 / 400, 16777216 / 20));
         end
         write_all(vals);
         if (phase == 10) calm = 1'b1;
         for (int i = 0; i < 100; i++) enqueue_current(random_current());
         if (phase == 4) want_long_hold <= 1'b1;
         drain();
      end

      repeat (1000) @(posedge clock);
      if (fail_count == 0) begin
         $display("adex_neuron_rk4_step_core: match");
      end else begin
         $display("adex_neuron_rk4_step_core: mismatch");
      end
      $finish;
   end

endmodule

// File: adex_neuron_rk4_step_core.f
hdl/adex_pkg.sv
hdl/adex_ifs.sv
hdl/adex_div.sv
hdl/adex_neuron_rk4_step_core.sv
hdl/adex_checker.sv
tb/tb_adex_neuron_rk4_step_core.sv
